// ===== design/iso_project_line_rasterizer_unit_assert.svh =====
// Assertion macros for the isometric line rasteriser.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef ISO_PROJECT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define ISO_PROJECT_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iplr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the isometric line rasteriser.
// No dependencies.
package iplr_pkg;

  localparam int GRID_BITS  = 10;
  localparam int COORD_BITS = 16;

  localparam int IN_GRID_W = 10;
  localparam int HGT_W     = 12;
  localparam int TAG_W     = 18;
  localparam int PIX_W     = 16;
  localparam int ZOOM_W    = 8;
  localparam int HS_W      = 8;
  localparam int TRIG_W    = 15;
  localparam int OFF_W     = 13;
  localparam int FRAME_W   = 13;
  localparam int Q14_FRAC  = 14;

  localparam int GRID_USE  = (GRID_BITS < IN_GRID_W) ? GRID_BITS : IN_GRID_W;
  localparam int PROD_W    = GRID_BITS + ZOOM_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MUL_W     = SUM_W + TRIG_W + 1;
  localparam int ACC_W     = MUL_W + 2;
  localparam int ZH_W      = HGT_W + HS_W;
  localparam int SPAN_W    = COORD_BITS + 1;
  localparam int ERR_W     = COORD_BITS + 3;
  localparam int VIS_W     = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 1;
  localparam int OUT_EXT_W = (COORD_BITS > PIX_W) ? COORD_BITS : PIX_W;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * PIX_W - TAG_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ISO_COS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ISO_SIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  localparam logic [ZOOM_W-1:0]         RST_ZOOM         = 8'd20;
  localparam logic signed [HS_W-1:0]    RST_HEIGHT_SCALE = 8'sd1;
  localparam logic [TRIG_W-1:0]         RST_ISO_COS      = 15'd14189;
  localparam logic [TRIG_W-1:0]         RST_ISO_SIN      = 15'd8192;
  localparam logic signed [OFF_W-1:0]   RST_OFFSET       = '0;
  localparam logic [FRAME_W-1:0]        RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [FRAME_W-1:0]        RST_FRAME_HEIGHT = 13'd1080;

  localparam logic signed [ACC_W-1:0] COORD_MAX = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);
  localparam logic signed [ZH_W-1:0]  TAG_MAX   = ZH_W'((64'sd1 <<< (TAG_W - 1)) - 1);
  localparam logic signed [ZH_W-1:0]  TAG_MIN   = -TAG_MAX - ZH_W'(1);
  localparam logic signed [MUL_W-1:0] Q14_BIAS  = MUL_W'((64'sd1 <<< Q14_FRAC) - 1);

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    logic [ZOOM_W-1:0]        zoom;
    logic signed [HS_W-1:0]   height_scale;
    logic [TRIG_W-1:0]        iso_cos_q14;
    logic [TRIG_W-1:0]        iso_sin_q14;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [OFF_W-1:0]  offset_y;
    logic [FRAME_W-1:0]       frame_width;
    logic [FRAME_W-1:0]       frame_height;
  } cfg_t;

  // lowest field last
  typedef struct packed {
    logic signed [HGT_W-1:0] end_height;
    logic [IN_GRID_W-1:0]    end_row;
    logic [IN_GRID_W-1:0]    end_col;
    logic signed [HGT_W-1:0] start_height;
    logic [IN_GRID_W-1:0]    start_row;
    logic [IN_GRID_W-1:0]    start_col;
  } in_item_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]    pad;
    logic signed [TAG_W-1:0] height_tag;
    logic [PIX_W-1:0]        pixel_y;
    logic [PIX_W-1:0]        pixel_x;
  } out_item_t;

  typedef struct packed {
    op_e                          op;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [SPAN_W-1:0]            sx;
    logic [SPAN_W-1:0]            sy;
    logic signed [TAG_W-1:0]      tag;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [GRID_BITS-1:0] grid_ext(input logic [IN_GRID_W-1:0] v);
    logic [GRID_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < GRID_USE; i++) r[i] = v[i];
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > COORD_MAX) r = COORD_MAX;
    else if (v < COORD_MIN) r = COORD_MIN;
    else r = v;
    return $signed(r[COORD_BITS-1:0]);
  endfunction

  function automatic logic signed [TAG_W-1:0] sat_tag(input logic signed [ZH_W-1:0] v);
    logic signed [ZH_W-1:0] r;
    if (v > TAG_MAX) r = TAG_MAX;
    else if (v < TAG_MIN) r = TAG_MIN;
    else r = v;
    return $signed(r[TAG_W-1:0]);
  endfunction

  // divide by 2^14, rounding toward zero
  function automatic logic signed [MUL_W-1:0] q14_trunc(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] b;
    b = (v < 0) ? (v + Q14_BIAS) : v;
    return b >>> Q14_FRAC;
  endfunction

endpackage

// ===== design/iplr_front.sv =====
// Front end: accepts items, queues steps, projects the two endpoints of a start item.
// Depends on iplr_pkg.
module iplr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iplr_pkg::cfg_t       cfg_i,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  iplr_pkg::op_e        s_op_i,
  input  iplr_pkg::in_item_t   s_data_i,
  input  iplr_pkg::q_status_t  q_stat_i,
  output logic                 q_push_o,
  output iplr_pkg::cmd_t       q_cmd_o
);
  import iplr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_ROT   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_SPAN  = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       pt_q, pt_d;
  in_item_t   item_q, item_d;

  logic [PROD_W-1:0]             ca_q, ca_d, ra_q, ra_d;
  logic signed [ZH_W-1:0]        z_q, z_d;
  logic signed [MUL_W-1:0]       mx_q, mx_d, my_q, my_d;
  logic signed [COORD_BITS-1:0]  ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [SPAN_W-1:0]             sx_q, sx_d, sy_q, sy_d;
  logic signed [TAG_W-1:0]       tag_q, tag_d;

  logic [IN_GRID_W-1:0]          col_sel, row_sel;
  logic signed [HGT_W-1:0]       h_sel;
  logic signed [SUM_W-1:0]       dif, sum;
  logic signed [COORD_BITS-1:0]  px, py;
  logic signed [SPAN_W-1:0]      dx, dy;
  logic                          accept;

  assign col_sel = pt_q ? item_q.end_col    : item_q.start_col;
  assign row_sel = pt_q ? item_q.end_row    : item_q.start_row;
  assign h_sel   = pt_q ? item_q.end_height : item_q.start_height;

  assign dif = $signed({2'b00, ca_q}) - $signed({2'b00, ra_q});
  assign sum = $signed({2'b00, ca_q}) + $signed({2'b00, ra_q});

  assign px = sat_coord(ACC_W'(q14_trunc(mx_q)) + ACC_W'(cfg_i.offset_x));
  assign py = sat_coord(ACC_W'(q14_trunc(my_q)) - ACC_W'(z_q) + ACC_W'(cfg_i.offset_y));

  assign dx = SPAN_W'(bx_q) - SPAN_W'(ax_q);
  assign dy = SPAN_W'(by_q) - SPAN_W'(ay_q);

  assign s_ready_o = (state_q == ST_IDLE) && !q_stat_i.full;
  assign accept    = s_valid_i && s_ready_o;

  assign q_push_o = (accept && (s_op_i == OP_STEP)) ||
                    ((state_q == ST_PUSH) && !q_stat_i.full);

  always_comb begin
    q_cmd_o     = '0;
    q_cmd_o.op  = (state_q == ST_PUSH) ? OP_START : OP_STEP;
    q_cmd_o.ax  = ax_q;
    q_cmd_o.ay  = ay_q;
    q_cmd_o.bx  = bx_q;
    q_cmd_o.by  = by_q;
    q_cmd_o.sx  = sx_q;
    q_cmd_o.sy  = sy_q;
    q_cmd_o.tag = tag_q;
  end

  always_comb begin
    state_d = state_q;
    pt_d    = pt_q;
    item_d  = item_q;
    ca_d    = ca_q;
    ra_d    = ra_q;
    z_d     = z_q;
    mx_d    = mx_q;
    my_d    = my_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    bx_d    = bx_q;
    by_d    = by_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    tag_d   = tag_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (s_op_i == OP_START)) begin
          item_d  = s_data_i;
          pt_d    = 1'b0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ca_d = PROD_W'(grid_ext(col_sel)) * PROD_W'(cfg_i.zoom);
        ra_d = PROD_W'(grid_ext(row_sel)) * PROD_W'(cfg_i.zoom);
        z_d  = ZH_W'(h_sel) * ZH_W'(cfg_i.height_scale);
        if (!pt_q) begin
          tag_d = sat_tag(ZH_W'(h_sel) * ZH_W'(cfg_i.height_scale));
        end
        state_d = ST_ROT;
      end
      ST_ROT: begin
        mx_d    = MUL_W'(dif) * $signed(MUL_W'(cfg_i.iso_cos_q14));
        my_d    = MUL_W'(sum) * $signed(MUL_W'(cfg_i.iso_sin_q14));
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!pt_q) begin
          ax_d    = px;
          ay_d    = py;
          pt_d    = 1'b1;
          state_d = ST_SCALE;
        end else begin
          bx_d    = px;
          by_d    = py;
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        sx_d    = (dx < 0) ? SPAN_W'(-dx) : SPAN_W'(dx);
        sy_d    = (dy < 0) ? SPAN_W'(-dy) : SPAN_W'(dy);
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_stat_i.full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pt_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ca_q   <= ca_d;
    ra_q   <= ra_d;
    z_q    <= z_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    tag_q  <= tag_d;
  end

endmodule

// ===== design/iplr_queue.sv =====
// Short command queue between front and back end.
// Depends on iplr_pkg.
module iplr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  iplr_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output iplr_pkg::cmd_t       cmd_o,
  output iplr_pkg::q_status_t  stat_o
);
  import iplr_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/iplr_back.sv =====
// Back end: Bresenham stepper and registered output stage.
// Depends on iplr_pkg.
module iplr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iplr_pkg::cfg_t       cfg_i,
  input  iplr_pkg::cmd_t       q_cmd_i,
  input  iplr_pkg::q_status_t  q_stat_i,
  output logic                 q_pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output iplr_pkg::out_item_t  m_data_o,
  output logic                 m_visible_o,
  output logic                 m_last_o
);
  import iplr_pkg::*;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [SPAN_W-1:0]            span_x_q, span_x_d, span_y_q, span_y_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic signed [TAG_W-1:0]      tag_q, tag_d;
  logic                         active_q, active_d;

  logic                         out_valid_q, out_valid_d;
  out_item_t                    out_data_q, out_data_d;
  logic                         out_vis_q, out_vis_d, out_last_q, out_last_d;

  logic signed [ERR_W:0]        e2, sx_e, sy_e;
  logic signed [ERR_W-1:0]      sx_n, sy_n;
  logic                         mv_x, mv_y, vis, done, out_free;
  logic signed [COORD_BITS-1:0] nx, ny;
  logic signed [OUT_EXT_W-1:0]  cx_ext, cy_ext;

  assign e2   = {err_q, 1'b0};
  assign sx_e = $signed((ERR_W + 1)'(span_x_q));
  assign sy_e = $signed((ERR_W + 1)'(span_y_q));
  assign sx_n = $signed(ERR_W'(span_x_q));
  assign sy_n = $signed(ERR_W'(span_y_q));
  assign mv_x = e2 > -sy_e;
  assign mv_y = e2 < sx_e;

  always_comb begin
    nx = cur_x_q;
    ny = cur_y_q;
    if (mv_x) begin
      if (cur_x_q < goal_x_q) nx = cur_x_q + COORD_BITS'(1);
      else if (cur_x_q > goal_x_q) nx = cur_x_q - COORD_BITS'(1);
    end
    if (mv_y) begin
      if (cur_y_q < goal_y_q) ny = cur_y_q + COORD_BITS'(1);
      else if (cur_y_q > goal_y_q) ny = cur_y_q - COORD_BITS'(1);
    end
  end

  assign done = (nx == goal_x_q) && (ny == goal_y_q);
  assign vis  = (VIS_W'(cur_x_q) >= 0) &&
                (VIS_W'(cur_x_q) < $signed(VIS_W'(cfg_i.frame_width))) &&
                (VIS_W'(cur_y_q) >= 0) &&
                (VIS_W'(cur_y_q) < $signed(VIS_W'(cfg_i.frame_height)));
  assign cx_ext = OUT_EXT_W'(cur_x_q);
  assign cy_ext = OUT_EXT_W'(cur_y_q);

  assign out_free = !out_valid_q || m_ready_i;
  assign q_pop_o  = !q_stat_i.empty && ((q_cmd_i.op == OP_START) || out_free);

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    err_d       = err_q;
    tag_d       = tag_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_vis_d   = out_vis_q;
    out_last_d  = out_last_q;
    if (m_ready_i) out_valid_d = 1'b0;
    if (q_pop_o) begin
      unique case (q_cmd_i.op)
        OP_START: begin
          cur_x_d  = q_cmd_i.ax;
          cur_y_d  = q_cmd_i.ay;
          goal_x_d = q_cmd_i.bx;
          goal_y_d = q_cmd_i.by;
          span_x_d = q_cmd_i.sx;
          span_y_d = q_cmd_i.sy;
          err_d    = $signed(ERR_W'(q_cmd_i.sx)) - $signed(ERR_W'(q_cmd_i.sy));
          tag_d    = q_cmd_i.tag;
          active_d = (q_cmd_i.ax != q_cmd_i.bx) || (q_cmd_i.ay != q_cmd_i.by);
        end
        OP_STEP: begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          if (active_q) begin
            out_data_d.pixel_x    = cx_ext[PIX_W-1:0];
            out_data_d.pixel_y    = cy_ext[PIX_W-1:0];
            out_data_d.height_tag = tag_q;
            out_vis_d  = vis;
            out_last_d = done;
            cur_x_d    = nx;
            cur_y_d    = ny;
            err_d      = err_q - (mv_x ? sy_n : '0) + (mv_y ? sx_n : '0);
            active_d   = !done;
          end else begin
            out_vis_d  = 1'b0;
            out_last_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    goal_x_q   <= goal_x_d;
    goal_y_q   <= goal_y_d;
    span_x_q   <= span_x_d;
    span_y_q   <= span_y_d;
    err_q      <= err_d;
    tag_q      <= tag_d;
    out_data_q <= out_data_d;
    out_vis_q  <= out_vis_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o   = out_valid_q;
  assign m_data_o    = out_data_q;
  assign m_visible_o = out_vis_q;
  assign m_last_o    = out_last_q;

endmodule

// ===== design/iso_project_line_rasterizer_unit.sv =====
// Step item: via queue and output register; one step item per cycle unless stalled.
// Start item: handled in the front end (scale, rotate, sum for each endpoint
// through its multipliers, then span), no result; the input is held off meanwhile.
// Results leave in input order through a four-entry command queue and an output register.
// Reset clears the queue, the stepper's line flag and the output; config registers take defaults.
// Depends on iplr_pkg, iplr_front, iplr_queue, iplr_back and the assertion header.
module iso_project_line_rasterizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [iplr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [iplr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_col, start_row, start_height, end_col, end_row, end_height
  input  logic [iplr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, height_tag, zero fill
  output logic [iplr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // visible
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import iplr_pkg::*;

  `include "iso_project_line_rasterizer_unit_assert.svh"

  cfg_t      cfg_q, cfg_d;
  logic      q_push, q_pop;
  cmd_t      q_in, q_out;
  q_status_t q_stat;
  out_item_t m_data;
  logic      m_vis;
  logic      step_acc;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ZOOM:         cfg_d.zoom         = cfg_data_i[ZOOM_W-1:0];
        REG_HEIGHT_SCALE: cfg_d.height_scale = $signed(cfg_data_i[HS_W-1:0]);
        REG_ISO_COS:      cfg_d.iso_cos_q14  = cfg_data_i[TRIG_W-1:0];
        REG_ISO_SIN:      cfg_d.iso_sin_q14  = cfg_data_i[TRIG_W-1:0];
        REG_OFFSET_X:     cfg_d.offset_x     = $signed(cfg_data_i[OFF_W-1:0]);
        REG_OFFSET_Y:     cfg_d.offset_y     = $signed(cfg_data_i[OFF_W-1:0]);
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i[FRAME_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom         <= RST_ZOOM;
      cfg_q.height_scale <= RST_HEIGHT_SCALE;
      cfg_q.iso_cos_q14  <= RST_ISO_COS;
      cfg_q.iso_sin_q14  <= RST_ISO_SIN;
      cfg_q.offset_x     <= RST_OFFSET;
      cfg_q.offset_y     <= RST_OFFSET;
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  iplr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_op_i    (op_e'(s_axis_tuser[0])),
    .s_data_i  (in_item_t'(s_axis_tdata)),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_cmd_o   (q_in)
  );

  iplr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_in),
    .pop_i  (q_pop),
    .cmd_o  (q_out),
    .stat_o (q_stat)
  );

  iplr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_cmd_i     (q_out),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_data),
    .m_visible_o (m_vis),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = m_data;
  assign m_axis_tuser = m_vis;

  assign step_acc = s_axis_tvalid && s_axis_tready && (op_e'(s_axis_tuser[0]) == OP_STEP);

  `IPLR_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `IPLR_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `IPLR_ASSERT_NEXT(a_step_queued, step_acc, !q_stat.empty, "accepted step item not queued")

endmodule

// ===== tb/iso_project_line_rasterizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for iso_project_line_rasterizer_unit: drives start and step items,
// predicts every pixel result in its own Bresenham model and checks it field by field.
// Depends on iplr_pkg and the rasteriser RTL.
module iso_project_line_rasterizer_unit_tb;
  import iplr_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RAND_SETTINGS = 8;
  localparam int ITEMS_PER_SET = 150;
  localparam int REPORT_CAP    = 40;

  typedef struct {
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [TAG_W-1:0] tag;
    logic                    vis;
    logic                    last;
  } pixel_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // predictor copy of registers and stepper
  cfg_t                         model_cfg;
  logic signed [COORD_BITS-1:0] pen_x, pen_y, goal_x, goal_y;
  logic [SPAN_W-1:0]            run_x, run_y;
  logic signed [ERR_W-1:0]      bres_err;
  logic signed [TAG_W-1:0]      tag_hgt;
  logic                         line_live;

  pixel_rec_t  pending_pixels[$];
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned lines_started = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_cycles   = 0;
  bit          tx_idle       = 1'b1;
  bit          rx_idle       = 1'b1;

  iso_project_line_rasterizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles, %0d results pending", $time, cycle_count,
               pending_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.zoom         = RST_ZOOM;
    c.height_scale = RST_HEIGHT_SCALE;
    c.iso_cos_q14  = RST_ISO_COS;
    c.iso_sin_q14  = RST_ISO_SIN;
    c.offset_x     = RST_OFFSET;
    c.offset_y     = RST_OFFSET;
    c.frame_width  = RST_FRAME_WIDTH;
    c.frame_height = RST_FRAME_HEIGHT;
    return c;
  endfunction

  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic void project_point(input logic [IN_GRID_W-1:0] col,
                                        input logic [IN_GRID_W-1:0] row,
                                        input logic signed [HGT_W-1:0] hgt,
                                        output longint px, output longint py);
    longint c, r, z, zm, hs, cs, sn, ox, oy;
    zm = model_cfg.zoom;
    hs = $signed(model_cfg.height_scale);
    cs = model_cfg.iso_cos_q14;
    sn = model_cfg.iso_sin_q14;
    ox = $signed(model_cfg.offset_x);
    oy = $signed(model_cfg.offset_y);
    c  = col;
    r  = row;
    z  = hgt;
    c  = c * zm;
    r  = r * zm;
    z  = z * hs;
    // longint division truncates toward zero
    px = clamp_signed((c - r) * cs / 16384 + ox, COORD_BITS);
    py = clamp_signed((c + r) * sn / 16384 - z + oy, COORD_BITS);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_ZOOM:         model_cfg.zoom         = value[ZOOM_W-1:0];
      REG_HEIGHT_SCALE: model_cfg.height_scale = value[HS_W-1:0];
      REG_ISO_COS:      model_cfg.iso_cos_q14  = value[TRIG_W-1:0];
      REG_ISO_SIN:      model_cfg.iso_sin_q14  = value[TRIG_W-1:0];
      REG_OFFSET_X:     model_cfg.offset_x     = value[OFF_W-1:0];
      REG_OFFSET_Y:     model_cfg.offset_y     = value[OFF_W-1:0];
      REG_FRAME_WIDTH:  model_cfg.frame_width  = value[FRAME_W-1:0];
      REG_FRAME_HEIGHT: model_cfg.frame_height = value[FRAME_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void rasterize_item(input op_e op, input in_item_t f);
    longint     ax, ay, bx, by, cx, cy, gx, gy, sx, sy, er, e2, fw, fh, zh;
    pixel_rec_t rec;
    if (op == OP_START) begin
      project_point(f.start_col, f.start_row, f.start_height, ax, ay);
      project_point(f.end_col, f.end_row, f.end_height, bx, by);
      sx        = (bx > ax) ? bx - ax : ax - bx;
      sy        = (by > ay) ? by - ay : ay - by;
      zh        = f.start_height;
      zh        = zh * longint'($signed(model_cfg.height_scale));
      pen_x     = ax[COORD_BITS-1:0];
      pen_y     = ay[COORD_BITS-1:0];
      goal_x    = bx[COORD_BITS-1:0];
      goal_y    = by[COORD_BITS-1:0];
      run_x     = sx[SPAN_W-1:0];
      run_y     = sy[SPAN_W-1:0];
      er        = sx - sy;
      bres_err  = er[ERR_W-1:0];
      zh        = clamp_signed(zh, TAG_W);
      tag_hgt   = zh[TAG_W-1:0];
      line_live = (ax != bx) || (ay != by);
      return;
    end
    if (!line_live) begin
      rec.px   = '0;
      rec.py   = '0;
      rec.tag  = '0;
      rec.vis  = 1'b0;
      rec.last = 1'b1;
    end else begin
      cx = pen_x;
      cy = pen_y;
      gx = goal_x;
      gy = goal_y;
      sx = run_x;
      sy = run_y;
      er = bres_err;
      fw = model_cfg.frame_width;
      fh = model_cfg.frame_height;
      rec.px  = cx[PIX_W-1:0];
      rec.py  = cy[PIX_W-1:0];
      rec.tag = tag_hgt;
      rec.vis = (cx >= 0) && (cx < fw) && (cy >= 0) && (cy < fh);
      e2 = 2 * er;
      if (e2 > -sy) begin
        er = er - sy;
        cx = cx + ((cx < gx) ? 1 : ((cx > gx) ? -1 : 0));
      end
      if (e2 < sx) begin
        er = er + sx;
        cy = cy + ((cy < gy) ? 1 : ((cy > gy) ? -1 : 0));
      end
      rec.last = (cx == gx) && (cy == gy);
      if (rec.last) line_live = 1'b0;
      pen_x    = cx[COORD_BITS-1:0];
      pen_y    = cy[COORD_BITS-1:0];
      bres_err = er[ERR_W-1:0];
    end
    pending_pixels.push_back(rec);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input op_e op, input in_item_t f);
    int unsigned gap;
    @(negedge clk_i);
    gap = $urandom_range(0, 7);
    if (!tx_idle) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = f;
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_item(op, f);
    items_sent++;
  endtask

  task automatic start_line(input int sc, input int sr, input int sh,
                            input int ec, input int er, input int eh);
    in_item_t f;
    f.start_col    = sc[IN_GRID_W-1:0];
    f.start_row    = sr[IN_GRID_W-1:0];
    f.start_height = sh[HGT_W-1:0];
    f.end_col      = ec[IN_GRID_W-1:0];
    f.end_row      = er[IN_GRID_W-1:0];
    f.end_height   = eh[HGT_W-1:0];
    send_item(OP_START, f);
    lines_started++;
  endtask

  // step items carry random, ignored content
  task automatic step_to_end(input int unsigned cap);
    int unsigned n;
    n = 0;
    while (line_live && n < cap) begin
      send_item(OP_STEP, {$urandom(), $urandom()});
      n++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    // a start item may still be in the front end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_config(input cfg_t c);
    wait_idle();
    write_reg(REG_ZOOM,         15'(c.zoom));
    write_reg(REG_HEIGHT_SCALE, 15'(c.height_scale));
    write_reg(REG_ISO_COS,      15'(c.iso_cos_q14));
    write_reg(REG_ISO_SIN,      15'(c.iso_sin_q14));
    write_reg(REG_OFFSET_X,     15'(c.offset_x));
    write_reg(REG_OFFSET_Y,     15'(c.offset_y));
    write_reg(REG_FRAME_WIDTH,  15'(c.frame_width));
    write_reg(REG_FRAME_HEIGHT, 15'(c.frame_height));
    settings_used++;
  endtask

  // receiver: random stalls per item, plus an optional long hold-off
  initial begin : pixel_sink
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = $urandom_range(0, 7);
      if (!rx_idle) gap = 0;
      if (hold_cycles != 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic flag_field(input string what, input longint want_v, input longint got_v);
    fail_count++;
    if (fail_count <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin : pixel_check
    out_item_t  got;
    pixel_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: pixel result with none pending, x %0d y %0d", $time,
                 $signed(got.pixel_x), $signed(got.pixel_y));
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_x !== want.px)
          flag_field("pixel_x", $signed(want.px), $signed(got.pixel_x));
        if (got.pixel_y !== want.py)
          flag_field("pixel_y", $signed(want.py), $signed(got.pixel_y));
        if (got.height_tag !== want.tag)
          flag_field("height_tag", want.tag, got.height_tag);
        if (m_axis_tuser[0] !== want.vis)
          flag_field("visible", want.vis, m_axis_tuser[0]);
        if (m_axis_tlast !== want.last)
          flag_field("last", want.last, m_axis_tlast);
        if (got.pad !== '0)
          flag_field("tdata fill", 0, got.pad);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_idle_step();
    send_item(OP_STEP, {$urandom(), $urandom()});
  endtask

  task automatic test_short_line();
    start_line(0, 0, 3, 0, 0, 0);
    step_to_end(8);
    send_item(OP_STEP, '1);
  endtask

  task automatic test_field_extremes();
    start_line(1023, 0, -2048, 0, 1023, 2047);
    step_to_end(2);
    // restart while the first line is still running
    start_line(0, 1023, 2047, 1023, 1023, -2048);
    step_to_end(2);
  endtask

  task automatic test_saturation();
    cfg_t c;
    c              = default_cfg();
    c.zoom         = 8'd255;
    c.height_scale = -8'sd128;
    c.iso_cos_q14  = 15'd16384;
    c.iso_sin_q14  = 15'd16384;
    c.offset_x     = 13'sd4095;
    c.offset_y     = -13'sd4096;
    write_config(c);
    start_line(1023, 0, -2048, 1023, 1023, 0);
    step_to_end(2);
    start_line(0, 1023, 2047, 1023, 0, 2047);
    step_to_end(1);
  endtask

  task automatic test_zero_length();
    cfg_t c;
    c      = default_cfg();
    c.zoom = 8'd0;
    write_config(c);
    start_line(5, 7, 10, 900, 3, 10);
    send_item(OP_STEP, {$urandom(), $urandom()});
  endtask

  task automatic test_frame_clip();
    cfg_t c;
    c              = default_cfg();
    c.zoom         = 8'd1;
    c.frame_width  = 13'd0;
    c.frame_height = 13'd0;
    write_config(c);
    start_line(0, 0, 0, 0, 0, 4);
    step_to_end(8);
    c.frame_width  = 13'd1;
    c.frame_height = 13'd1;
    write_config(c);
    start_line(0, 0, 0, 0, 0, -3);
    step_to_end(8);
  endtask

  task automatic test_backpressure();
    write_config(default_cfg());
    tx_idle     = 1'b0;
    hold_cycles = 300;
    start_line(0, 0, 0, 20, 0, 0);
    step_to_end(60);
    tx_idle = 1'b1;
  endtask

  function automatic cfg_t pick_config(input int k);
    cfg_t c;
    c = default_cfg();
    if (k == 1) begin
      c.zoom         = 8'd1;
      c.height_scale = -8'sd64;
      c.iso_cos_q14  = 15'd0;
      c.iso_sin_q14  = 15'd0;
      c.offset_x     = -13'sd4096;
      c.offset_y     = -13'sd4096;
      c.frame_width  = 13'd1;
      c.frame_height = 13'd1;
    end else if (k == 2) begin
      c.zoom         = 8'd255;
      c.height_scale = 8'sd64;
      c.iso_cos_q14  = 15'd16384;
      c.iso_sin_q14  = 15'd16384;
      c.offset_x     = 13'sd4095;
      c.offset_y     = 13'sd4095;
      c.frame_width  = 13'd4096;
      c.frame_height = 13'd4096;
    end else if (k > 2) begin
      c.zoom         = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 6));
      c.height_scale = 8'(int'($urandom_range(0, 128)) - 64);
      c.iso_cos_q14  = 15'($urandom_range(0, 16384));
      c.iso_sin_q14  = 15'($urandom_range(0, 16384));
      c.offset_x     = 13'(int'($urandom_range(0, 8191)) - 4096);
      c.offset_y     = 13'(int'($urandom_range(0, 8191)) - 4096);
      c.frame_width  = 13'($urandom_range(1, 4096));
      c.frame_height = 13'($urandom_range(1, 4096));
    end
    return c;
  endfunction

  task automatic test_random_lines();
    in_item_t    f;
    int unsigned budget;
    for (int k = 0; k < RAND_SETTINGS; k++) begin
      write_config(pick_config(k));
      tx_idle = (k % 3) != 2;
      rx_idle = (k % 4) != 1;
      budget  = items_sent + ITEMS_PER_SET;
      while (items_sent < budget) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise: any opcode, any content
          send_item(op_e'($urandom_range(0, 1)), {$urandom(), $urandom()});
        end else begin
          f = {$urandom(), $urandom()};
          // mostly short lines, end point near the start point
          if ($urandom_range(0, 4) != 0) begin
            f.end_col    = f.start_col + 10'($urandom_range(0, 4)) - 10'd2;
            f.end_row    = f.start_row + 10'($urandom_range(0, 4)) - 10'd2;
            f.end_height = f.start_height + 12'($urandom_range(0, 16)) - 12'd8;
          end
          send_item(OP_START, f);
          lines_started++;
          step_to_end($urandom_range(4, 48));
          if (!line_live && $urandom_range(0, 3) == 0)
            send_item(OP_STEP, {$urandom(), $urandom()});
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ZOOM;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_START;
    model_cfg     = default_cfg();
    pen_x         = '0;
    pen_y         = '0;
    goal_x        = '0;
    goal_y        = '0;
    run_x         = '0;
    run_y         = '0;
    bres_err      = '0;
    tag_hgt       = '0;
    line_live     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_step();
    test_short_line();
    test_field_extremes();
    test_saturation();
    test_zero_length();
    test_frame_clip();
    test_backpressure();
    test_random_lines();
    wait_idle();

    $display("Sent %0d items (%0d line starts) under %0d register settings;", items_sent,
             lines_started, settings_used);
    $display("checked %0d pixel results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/iplr_pkg.sv
design/iplr_front.sv
design/iplr_queue.sv
design/iplr_back.sv
design/iso_project_line_rasterizer_unit.sv
tb/iso_project_line_rasterizer_unit_tb.sv
